// File: rtl/core/nvpf_pkg.sv
`timescale 1ns / 1ps
package nvpf_pkg;
   localparam int unsigned MaxLinesDef = 256;
   localparam int unsigned MaxColsDef = 256;
   localparam int unsigned RegW = 9;
   localparam logic [RegW-1:0] LinesReset = 9'd256;
   localparam logic [RegW-1:0] ColsReset = 9'd256;
   localparam logic CsrActiveLines = 1'b0;
   localparam logic CsrActiveCols = 1'b1;
   localparam logic OpWrite = 1'b0;
   localparam logic OpQuery = 1'b1;

   typedef struct packed {
      logic              op;
      logic [7:0]        row;
      logic [7:0]        column;
      logic signed [15:0] pixel_value;
      logic              valid_mask;
   } req_type;

   typedef struct packed {
      logic              found;
      logic signed [15:0] fill_value;
      logic [7:0]        near_row;
      logic [7:0]        near_col;
      logic [16:0]       dist_squared;
   } rsp_type;
endpackage

// File: rtl/core/nearest_valid_pixel_fill.sv
`timescale 1ns / 1ps
// Channel  Direction  Payload   Accepted when
// req      in         req_type  req_valid && req_ready
// rsp      out        rsp_type  rsp_valid && rsp_ready
// csr      in         9 bits    csr_we (index 0 lines, 1 columns)
//
// After reset the block clears the mask memory, one entry a cycle, all
// 2**(LW+CW) entries (65536 with the default sizes), and takes no beat meanwhile.
// A write is taken in idle and the block stays idle.
// A query outside the frame goes from the center read straight to output, and
// one at a valid pixel passes center read, fetch, value read and output.
// A hole sweeps rings of growing n, visiting all 8n positions of each ring, in the
// frame or not, then draining the last mask read. The sweep stops one ring
// after the first ring with a hit, or at the larger frame size.
// The output register holds a finished beat while rsp_ready is low. Writes are
// still taken then, and a finished query waits in its output state.
module nearest_valid_pixel_fill
   import nvpf_pkg::*;
#(
   parameter int unsigned MAX_LINES = MaxLinesDef,
   parameter int unsigned MAX_COLS = MaxColsDef
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_type         req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_type         rsp_data,
   input  logic            csr_we,
   input  logic            csr_index,
   input  logic [RegW-1:0] csr_wdata
);
   localparam int unsigned LW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
   localparam int unsigned CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int unsigned AW = LW + CW;
   localparam int unsigned Depth = 1 << AW;
   localparam int unsigned SW = 14;        // signed probe coordinates
   localparam int unsigned DW = RegW + 1;  // signed offsets from the query
   localparam int unsigned PW = 13;        // holds size parameters below 8192
   localparam logic [PW-1:0] LinesCap = PW'(MAX_LINES);
   localparam logic [PW-1:0] ColsCap = PW'(MAX_COLS);

   // Ring segments in sweep order.
   localparam logic [2:0] SegTopLeft = 3'd0;
   localparam logic [2:0] SegLeft = 3'd1;
   localparam logic [2:0] SegBottom = 3'd2;
   localparam logic [2:0] SegRight = 3'd3;
   localparam logic [2:0] SegTopRight = 3'd4;

   typedef enum logic [7:0] {
      S_CLEAR = 8'b00000001, S_IDLE = 8'b00000010, S_CENTER = 8'b00000100,
      S_FETCH = 8'b00001000, S_PROBE = 8'b00010000, S_DRAIN = 8'b00100000,
      S_FVAL = 8'b01000000, S_OUT = 8'b10000000
   } state_type;

   state_type state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [RegW-1:0] lines_ff, cols_ff;
   logic [7:0] qr_ff, qc_ff, qr_in, qc_in;
   logic [RegW-1:0] fl_ff, fc_ff, fl_in, fc_in, maxn_ff, maxn_in;
   logic [RegW-1:0] n_ff, n_in;
   logic [2:0] seg_ff, seg_in;
   logic [DW-1:0] t_ff, t_in;
   logic hit_ff, hit_in, extra_ff, extra_in;
   logic [16:0] bd_ff, bd_in;
   logic [7:0] br_ff, bc_ff, br_in, bc_in;
   logic pend_ff, pend_in;      // a probe read in flight
   logic signed [DW-1:0] pdr_ff, pdc_ff, pdr_in, pdc_in;
   logic [7:0] ppr_ff, ppc_ff, ppr_in, ppc_in;
   logic rv_ff, rv_in;
   rsp_type rsp_ff, rsp_in;

   logic m_we, m_wd, m_rd, v_we;
   logic [AW-1:0] m_wa, m_ra, v_ra;
   logic [15:0] v_rd;
   logic acc, in_store;

   nvpf_ram #(.Width(1), .Depth(Depth)) u_mask (
      .clock(clock), .wr_en(m_we), .wr_addr(m_wa), .wr_data(m_wd),
      .rd_addr(m_ra), .rd_data(m_rd));
   nvpf_ram #(.Width(16), .Depth(Depth)) u_value (
      .clock(clock), .wr_en(v_we), .wr_addr(m_wa), .wr_data(req_data.pixel_value),
      .rd_addr(v_ra), .rd_data(v_rd));

   // Position and offset of the probe at ring n, segment seg, step t.
   logic signed [SW-1:0] qr_s, qc_s, n_s, t_s, fl_s, fc_s, pr, pc;
   logic signed [DW-1:0] dr, dc;
   logic [DW-1:0] seg_end;
   logic in_frame, seg_last, ring_last;
   always_comb begin
      qr_s = SW'(qr_ff);
      qc_s = SW'(qc_ff);
      n_s = SW'(n_ff);
      t_s = SW'(t_ff);
      fl_s = SW'(fl_ff);
      fc_s = SW'(fc_ff);
      case (seg_ff)
         SegTopLeft: begin
            pr = qr_s - n_s; pc = qc_s - t_s;
            dr = DW'(-n_s); dc = DW'(-t_s); seg_end = {1'b0, n_ff};
         end
         SegLeft: begin
            pr = qr_s - n_s + t_s; pc = qc_s - n_s;
            dr = DW'(t_s - n_s); dc = DW'(-n_s); seg_end = {n_ff, 1'b0};
         end
         SegBottom: begin
            pr = qr_s + n_s; pc = qc_s - n_s + t_s;
            dr = DW'(n_s); dc = DW'(t_s - n_s); seg_end = {n_ff, 1'b0};
         end
         SegRight: begin
            pr = qr_s + n_s - t_s; pc = qc_s + n_s;
            dr = DW'(n_s - t_s); dc = DW'(n_s); seg_end = {n_ff, 1'b0};
         end
         default: begin
            pr = qr_s - n_s; pc = qc_s + n_s - t_s;
            dr = DW'(-n_s); dc = DW'(n_s - t_s); seg_end = {1'b0, n_ff} - 1'b1;
         end
      endcase
      in_frame = !pr[SW-1] && !pc[SW-1] && pr < fl_s && pc < fc_s;
      seg_last = t_ff == seg_end;
      // Ring one has no closing top-right run, so it ends on the right column.
      ring_last = seg_last && (seg_ff == SegTopRight ||
                               (seg_ff == SegRight && n_ff == RegW'(1)));
   end

   // Squared distance of the probe whose mask bit arrives this cycle. Only
   // valid pixels are compared, and those lie within 255 of the query.
   logic signed [19:0] sq_r, sq_c;
   logic [16:0] pd;
   always_comb begin
      sq_r = 20'(pdr_ff) * 20'(pdr_ff);
      sq_c = 20'(pdc_ff) * 20'(pdc_ff);
      pd = 17'(sq_r + sq_c);
   end

   assign req_ready = state_ff == S_IDLE;
   assign acc = req_valid && req_ready;
   assign rsp_valid = rv_ff;
   assign rsp_data = rsp_ff;
   assign v_ra = {LW'(br_ff), CW'(bc_ff)};
   assign in_store = PW'(req_data.row) < LinesCap && PW'(req_data.column) < ColsCap;

   always_comb begin
      state_in = state_ff; clr_in = clr_ff; qr_in = qr_ff; qc_in = qc_ff;
      fl_in = fl_ff; fc_in = fc_ff; maxn_in = maxn_ff;
      n_in = n_ff; seg_in = seg_ff; t_in = t_ff;
      hit_in = hit_ff; extra_in = extra_ff; bd_in = bd_ff; br_in = br_ff; bc_in = bc_ff;
      pend_in = 1'b0; pdr_in = pdr_ff; pdc_in = pdc_ff; ppr_in = ppr_ff; ppc_in = ppc_ff;
      rv_in = rv_ff && !rsp_ready; rsp_in = rsp_ff;
      m_we = 1'b0; v_we = 1'b0;
      m_wa = {LW'(req_data.row), CW'(req_data.column)};
      m_wd = req_data.valid_mask;
      m_ra = {LW'(qr_ff), CW'(qc_ff)};
      // Resolve the probe read issued last cycle. Only a strictly closer pixel
      // replaces the best one, so ties keep the first in sweep order.
      if (pend_ff && m_rd && (!hit_ff || pd < bd_ff)) begin
         hit_in = 1'b1; bd_in = pd; br_in = ppr_ff; bc_in = ppc_ff;
      end
      case (state_ff)
         S_CLEAR: begin
            m_we = 1'b1; m_wd = 1'b0; m_wa = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == '1) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (acc) begin
               if (req_data.op == OpWrite) begin
                  m_we = in_store;
                  v_we = in_store;
               end else begin
                  qr_in = req_data.row;
                  qc_in = req_data.column;
                  fl_in = (PW'(lines_ff) > LinesCap) ? RegW'(LinesCap) : lines_ff;
                  fc_in = (PW'(cols_ff) > ColsCap) ? RegW'(ColsCap) : cols_ff;
                  hit_in = 1'b0; extra_in = 1'b0; bd_in = '0; br_in = '0; bc_in = '0;
                  state_in = S_CENTER;
               end
            end
         end
         S_CENTER: begin
            // The mask bit of the center is read this cycle.
            maxn_in = (fl_ff > fc_ff) ? fl_ff : fc_ff;
            n_in = RegW'(1); seg_in = SegTopLeft; t_in = '0;
            if ({1'b0, qr_ff} < fl_ff && {1'b0, qc_ff} < fc_ff) state_in = S_FETCH;
            else state_in = S_OUT;
         end
         S_FETCH: begin
            if (m_rd) begin
               hit_in = 1'b1; br_in = qr_ff; bc_in = qc_ff;
               state_in = S_FVAL;
            end else begin
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            if (in_frame) begin
               m_ra = {LW'(pr), CW'(pc)};
               pend_in = 1'b1; pdr_in = dr; pdc_in = dc;
               ppr_in = 8'(pr); ppc_in = 8'(pc);
            end
            if (ring_last) begin
               state_in = S_DRAIN;
            end else if (seg_last) begin
               seg_in = seg_ff + 3'd1; t_in = DW'(1);
            end else begin
               t_in = t_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            // The last read of the ring has landed; the ring after the first ring with a hit, or
            // the ring at the larger frame size, ends the sweep.
            if ((hit_in && extra_ff) || n_ff == maxn_ff) begin
               state_in = hit_in ? S_FVAL : S_OUT;
            end else begin
               extra_in = hit_in;
               n_in = n_ff + 1'b1; seg_in = SegTopLeft; t_in = '0;
               state_in = S_PROBE;
            end
         end
         S_FVAL: begin
            // The value memory reads the best pixel this cycle.
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rv_ff || rsp_ready) begin
               rv_in = 1'b1;
               rsp_in.found = hit_ff;
               rsp_in.fill_value = hit_ff ? v_rd : '0;
               rsp_in.near_row = hit_ff ? br_ff : '0;
               rsp_in.near_col = hit_ff ? bc_ff : '0;
               rsp_in.dist_squared = hit_ff ? bd_ff : '0;
               state_in = S_IDLE;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; clr_ff <= '0; rv_ff <= 1'b0; pend_ff <= 1'b0;
         lines_ff <= LinesReset; cols_ff <= ColsReset;
      end else begin
         state_ff <= state_in; clr_ff <= clr_in; rv_ff <= rv_in; pend_ff <= pend_in;
         if (csr_we && csr_index == CsrActiveLines) lines_ff <= csr_wdata;
         if (csr_we && csr_index == CsrActiveCols) cols_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      qr_ff <= qr_in; qc_ff <= qc_in; fl_ff <= fl_in; fc_ff <= fc_in;
      maxn_ff <= maxn_in; n_ff <= n_in; seg_ff <= seg_in; t_ff <= t_in;
      hit_ff <= hit_in; extra_ff <= extra_in;
      bd_ff <= bd_in; br_ff <= br_in; bc_ff <= bc_in;
      pdr_ff <= pdr_in; pdc_ff <= pdc_in; ppr_ff <= ppr_in; ppc_ff <= ppc_in;
      rsp_ff <= rsp_in;
   end

   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");
   a_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == S_IDLE) else $error("ready outside idle");
endmodule

// File: rtl/core/nvpf_ram.sv
`timescale 1ns / 1ps
module nvpf_ram #(
   parameter int unsigned Width = 16,
   parameter int unsigned Depth = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
